// File: hw/rtl/dsc_pkg.sv
`timescale 1ns / 1ps

package dsc_pkg;

    localparam logic [3:0] ST_UNKNOWN    = 4'd0;
    localparam logic [3:0] ST_NOT_READY  = 4'd1;
    localparam logic [3:0] ST_DISABLED   = 4'd2;
    localparam logic [3:0] ST_READY      = 4'd3;
    localparam logic [3:0] ST_SWITCHED   = 4'd4;
    localparam logic [3:0] ST_ENABLED    = 4'd5;
    localparam logic [3:0] ST_QUICK_STOP = 4'd6;
    localparam logic [3:0] ST_FAULT_RXN  = 4'd7;
    localparam logic [3:0] ST_FAULT      = 4'd8;

    localparam logic [15:0] CW_SO = 16'h0001;
    localparam logic [15:0] CW_EV = 16'h0002;
    localparam logic [15:0] CW_QS = 16'h0004;
    localparam logic [15:0] CW_EO = 16'h0008;
    localparam logic [15:0] CW_FR = 16'h0080;

    localparam int unsigned SW_LIMIT_BIT = 11;

    localparam logic [1:0] LIM_NONE  = 2'd0;
    localparam logic [1:0] LIM_WARN  = 2'd1;
    localparam logic [1:0] LIM_ERROR = 2'd2;

    typedef struct packed {
        logic        ok;
        logic [15:0] set_mask;
        logic [15:0] clr_mask;
    } t_entry;

    typedef struct packed {
        logic [3:0]  drive_state;
        logic        state_changed;
        logic [3:0]  hop_state;
        logic [15:0] control_word;
        logic        transition_ok;
        logic        at_target;
        logic [1:0]  limit_status;
    } t_result;

    function automatic logic [3:0] decode_status(input logic [15:0] sw);
        logic [6:0] bits;
        bits = sw[6:0] & 7'h6F;
        case (bits)
            7'h00, 7'h20: decode_status = ST_NOT_READY;
            7'h40, 7'h60: decode_status = ST_DISABLED;
            7'h21:        decode_status = ST_READY;
            7'h23:        decode_status = ST_SWITCHED;
            7'h27:        decode_status = ST_ENABLED;
            7'h07:        decode_status = ST_QUICK_STOP;
            7'h0F, 7'h2F: decode_status = ST_FAULT_RXN;
            7'h08, 7'h28: decode_status = ST_FAULT;
            default:      decode_status = ST_UNKNOWN;
        endcase
    endfunction

    function automatic logic [3:0] step_toward_enabled(input logic [3:0] st);
        case (st)
            ST_UNKNOWN:                          step_toward_enabled = ST_NOT_READY;
            ST_NOT_READY, ST_FAULT:              step_toward_enabled = ST_DISABLED;
            ST_DISABLED:                         step_toward_enabled = ST_READY;
            ST_READY:                            step_toward_enabled = ST_SWITCHED;
            ST_SWITCHED, ST_ENABLED,
            ST_QUICK_STOP:                       step_toward_enabled = ST_ENABLED;
            ST_FAULT_RXN:                        step_toward_enabled = ST_FAULT;
            default:                             step_toward_enabled = ST_ENABLED;
        endcase
    endfunction

    function automatic t_entry lookup(input logic [3:0] from_st, input logic [3:0] to_st);
        t_entry e;
        e = '{ok: 1'b1, set_mask: 16'h0000, clr_mask: 16'h0000};
        case ({from_st, to_st})
            {ST_READY, ST_DISABLED}, {ST_ENABLED, ST_DISABLED},
            {ST_SWITCHED, ST_DISABLED}, {ST_QUICK_STOP, ST_DISABLED}: begin
                e.clr_mask = CW_FR | CW_EV;
            end
            {ST_UNKNOWN, ST_NOT_READY}, {ST_NOT_READY, ST_DISABLED},
            {ST_FAULT_RXN, ST_FAULT}: begin
                e.set_mask = 16'h0000;
            end
            {ST_DISABLED, ST_READY}, {ST_SWITCHED, ST_READY},
            {ST_ENABLED, ST_READY}: begin
                e.set_mask = CW_QS | CW_EV;
                e.clr_mask = CW_FR | CW_SO;
            end
            {ST_READY, ST_SWITCHED}, {ST_ENABLED, ST_SWITCHED}: begin
                e.set_mask = CW_QS | CW_EV | CW_SO;
                e.clr_mask = CW_FR | CW_EO;
            end
            {ST_SWITCHED, ST_ENABLED}, {ST_QUICK_STOP, ST_ENABLED}: begin
                e.set_mask = CW_QS | CW_EV | CW_SO | CW_EO;
                e.clr_mask = CW_FR;
            end
            {ST_READY, ST_QUICK_STOP}, {ST_SWITCHED, ST_QUICK_STOP},
            {ST_ENABLED, ST_QUICK_STOP}: begin
                e.set_mask = CW_EV;
                e.clr_mask = CW_FR | CW_QS;
            end
            {ST_FAULT, ST_DISABLED}: begin
                e.set_mask = CW_FR;
            end
            default: begin
                e.ok = 1'b0;
            end
        endcase
        lookup = e;
    endfunction

endpackage

// File: hw/rtl/dsc_xlate.sv
`timescale 1ns / 1ps

module dsc_xlate
    import dsc_pkg::*;
(
    input  logic [15:0] i_status_word,
    input  logic [3:0]  i_target_state,
    input  logic        i_layer_ready,
    input  logic [3:0]  i_last_state,
    input  logic [15:0] i_control_reg,
    input  logic        i_prev_limit,
    output t_result     o_result
);

    logic [3:0]  st;
    logic [3:0]  hop;
    logic        at_tgt;
    logic        limit_now;
    t_entry      ent;

    always_comb begin
        st        = decode_status(i_status_word);
        at_tgt    = (st == i_target_state);
        hop       = (i_target_state == ST_ENABLED) ? step_toward_enabled(st)
                                                   : i_target_state;
        ent       = lookup(st, hop);
        limit_now = i_status_word[SW_LIMIT_BIT];

        o_result.drive_state   = st;
        o_result.state_changed = (st != i_last_state);
        o_result.at_target     = at_tgt;
        if (at_tgt) begin
            o_result.hop_state     = i_target_state;
            o_result.control_word  = i_control_reg;
            o_result.transition_ok = 1'b1;
        end else begin
            o_result.hop_state     = hop;
            o_result.transition_ok = ent.ok;
            o_result.control_word  = ent.ok
                ? ((i_control_reg | ent.set_mask) & ~ent.clr_mask)
                : i_control_reg;
        end

        if (!limit_now) begin
            o_result.limit_status = LIM_NONE;
        end else if (i_prev_limit || !i_layer_ready) begin
            o_result.limit_status = LIM_WARN;
        end else begin
            o_result.limit_status = LIM_ERROR;
        end
    end

endmodule

// File: hw/rtl/drive_state_controller_unit.sv
`timescale 1ns / 1ps

// Channel | Handshake             | Payload
// input   | i_valid / o_stall     | i_status_word, i_target_state, i_layer_ready
// output  | o_valid / i_stall     | o_drive_state .. o_limit_status
//
// One item per clock sustained while the output is not stalled.
// An input register feeds the decode and table logic, whose result lands in
// the output register; drive state, control word and limit history advance
// as an item moves into the output register. Synchronous active-low reset
// clears the kept state and both valid flags. A stall on the output holds
// both registers and stalls the input once the input register is full.

module drive_state_controller_unit
    import dsc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_status_word,
    input  logic [3:0]  i_target_state,
    input  logic        i_layer_ready,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_drive_state,
    output logic        o_state_changed,
    output logic [3:0]  o_hop_state,
    output logic [15:0] o_control_word,
    output logic        o_transition_ok,
    output logic        o_at_target,
    output logic [1:0]  o_limit_status
);

    logic        r_in_valid;
    logic [15:0] r_status_word;
    logic [3:0]  r_target_state;
    logic        r_layer_ready;
    logic        r_out_valid;
    t_result     r_out;
    logic [3:0]  r_last_state;
    logic [15:0] r_control_reg;
    logic        r_prev_limit;
    t_result     n_out;
    logic        adv;
    logic        in_xfer;

    assign adv     = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !adv;
    assign in_xfer = i_valid && !o_stall;

    dsc_xlate u_xlate (
        .i_status_word  (r_status_word),
        .i_target_state (r_target_state),
        .i_layer_ready  (r_layer_ready),
        .i_last_state   (r_last_state),
        .i_control_reg  (r_control_reg),
        .i_prev_limit   (r_prev_limit),
        .o_result       (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_last_state  <= ST_UNKNOWN;
            r_control_reg <= 16'h0000;
            r_prev_limit  <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid   <= 1'b1;
                r_last_state  <= n_out.drive_state;
                r_control_reg <= n_out.control_word;
                r_prev_limit  <= r_status_word[SW_LIMIT_BIT];
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_status_word  <= i_status_word;
            r_target_state <= i_target_state;
            r_layer_ready  <= i_layer_ready;
        end
        if (adv) begin
            r_out <= n_out;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_drive_state   = r_out.drive_state;
    assign o_state_changed = r_out.state_changed;
    assign o_hop_state     = r_out.hop_state;
    assign o_control_word  = r_out.control_word;
    assign o_transition_ok = r_out.transition_ok;
    assign o_at_target     = r_out.at_target;
    assign o_limit_status  = r_out.limit_status;

    a_adv_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> o_valid)
        else $error("advancing item did not reach output register");

    a_stall_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> r_in_valid)
        else $error("stalled input item was dropped");

    a_target_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_at_target |-> o_transition_ok && (o_hop_state == o_drive_state))
        else $error("result at target with inconsistent hop or flag");

    a_ctrl_tracks_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_control_word == r_control_reg) && (o_drive_state == r_last_state))
        else $error("kept state differs from last delivered result");

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import dsc_pkg::*;

    localparam int N_RANDOM    = 425;
    localparam int CYCLE_LIMIT = 200000;
    localparam logic [15:0] STATE_BITS = 16'h006F;

    typedef struct {
        logic [15:0] sw;
        logic [3:0]  tgt;
        logic        rdy;
        bit          typed;
        t_result     res;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [15:0] i_status_word;
    logic [3:0]  i_target_state;
    logic        i_layer_ready;
    logic        o_valid;
    logic        i_stall;
    logic [3:0]  o_drive_state;
    logic        o_state_changed;
    logic [3:0]  o_hop_state;
    logic [15:0] o_control_word;
    logic        o_transition_ok;
    logic        o_at_target;
    logic [1:0]  o_limit_status;

    logic [3:0]  seen_state;
    logic [15:0] control_kept;
    logic        limit_seen;
    t_result     pending_responses[$];
    int          mismatches = 0;
    int          cycles = 0;
    bit          calm = 1'b0;
    int          stall_left = 0;

    drive_state_controller_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_status_word   (i_status_word),
        .i_target_state  (i_target_state),
        .i_layer_ready   (i_layer_ready),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_drive_state   (o_drive_state),
        .o_state_changed (o_state_changed),
        .o_hop_state     (o_hop_state),
        .o_control_word  (o_control_word),
        .o_transition_ok (o_transition_ok),
        .o_at_target     (o_at_target),
        .o_limit_status  (o_limit_status)
    );

    always #1 i_clk = ~i_clk;

    function automatic logic [3:0] decode_drive(input logic [15:0] sw);
        case (sw & STATE_BITS)
            16'h0000, 16'h0020: return ST_NOT_READY;
            16'h0040, 16'h0060: return ST_DISABLED;
            16'h0021:           return ST_READY;
            16'h0023:           return ST_SWITCHED;
            16'h0027:           return ST_ENABLED;
            16'h0007:           return ST_QUICK_STOP;
            16'h000F, 16'h002F: return ST_FAULT_RXN;
            16'h0008, 16'h0028: return ST_FAULT;
            default:            return ST_UNKNOWN;
        endcase
    endfunction

    function automatic logic [3:0] next_toward_enabled(input logic [3:0] st);
        case (st)
            ST_UNKNOWN:                            return ST_NOT_READY;
            ST_NOT_READY, ST_FAULT:                return ST_DISABLED;
            ST_DISABLED:                           return ST_READY;
            ST_READY:                              return ST_SWITCHED;
            ST_FAULT_RXN:                          return ST_FAULT;
            default:                               return ST_ENABLED;
        endcase
    endfunction

    function automatic bit transition_masks(input logic [3:0] from_st, input logic [3:0] to_st,
                                            output logic [15:0] set_m,
                                            output logic [15:0] clr_m);
        set_m = '0;
        clr_m = '0;
        case ({from_st, to_st})
            {ST_READY, ST_DISABLED}, {ST_SWITCHED, ST_DISABLED},
            {ST_ENABLED, ST_DISABLED}, {ST_QUICK_STOP, ST_DISABLED}:
                clr_m = CW_FR | CW_EV;
            {ST_UNKNOWN, ST_NOT_READY}, {ST_NOT_READY, ST_DISABLED},
            {ST_FAULT_RXN, ST_FAULT}: ;
            {ST_DISABLED, ST_READY}, {ST_SWITCHED, ST_READY}, {ST_ENABLED, ST_READY}: begin
                set_m = CW_QS | CW_EV;
                clr_m = CW_FR | CW_SO;
            end
            {ST_READY, ST_SWITCHED}, {ST_ENABLED, ST_SWITCHED}: begin
                set_m = CW_QS | CW_EV | CW_SO;
                clr_m = CW_FR | CW_EO;
            end
            {ST_SWITCHED, ST_ENABLED}, {ST_QUICK_STOP, ST_ENABLED}: begin
                set_m = CW_QS | CW_EV | CW_SO | CW_EO;
                clr_m = CW_FR;
            end
            {ST_READY, ST_QUICK_STOP}, {ST_SWITCHED, ST_QUICK_STOP},
            {ST_ENABLED, ST_QUICK_STOP}: begin
                set_m = CW_EV;
                clr_m = CW_FR | CW_QS;
            end
            {ST_FAULT, ST_DISABLED}:
                set_m = CW_FR;
            default:
                return 1'b0;
        endcase
        return 1'b1;
    endfunction

    function automatic t_result drive_response(input logic [15:0] sw, input logic [3:0] tgt,
                                               input logic rdy);
        t_result     r;
        logic [15:0] set_m;
        logic [15:0] clr_m;
        logic        lim;
        r.drive_state   = decode_drive(sw);
        r.state_changed = r.drive_state != seen_state;
        r.hop_state     = tgt;
        r.transition_ok = 1'b1;
        seen_state      = r.drive_state;
        if (r.drive_state != tgt) begin
            if (tgt == ST_ENABLED)
                r.hop_state = next_toward_enabled(r.drive_state);
            if (transition_masks(r.drive_state, r.hop_state, set_m, clr_m))
                control_kept = (control_kept | set_m) & ~clr_m;
            else
                r.transition_ok = 1'b0;
        end
        r.control_word = control_kept;
        r.at_target    = r.drive_state == tgt;
        lim            = sw[SW_LIMIT_BIT];
        if (!lim)
            r.limit_status = LIM_NONE;
        else if (limit_seen || !rdy)
            r.limit_status = LIM_WARN;
        else
            r.limit_status = LIM_ERROR;
        limit_seen = lim;
        return r;
    endfunction

    function automatic logic [15:0] status_bits_for(input logic [3:0] st);
        bit alt;
        alt = 1'($urandom_range(0, 1));
        case (st)
            ST_NOT_READY:  return alt ? 16'h0020 : 16'h0000;
            ST_DISABLED:   return alt ? 16'h0060 : 16'h0040;
            ST_READY:      return 16'h0021;
            ST_SWITCHED:   return 16'h0023;
            ST_ENABLED:    return 16'h0027;
            ST_QUICK_STOP: return 16'h0007;
            ST_FAULT_RXN:  return alt ? 16'h002F : 16'h000F;
            ST_FAULT:      return alt ? 16'h0028 : 16'h0008;
            default: begin
                case ($urandom_range(0, 3))
                    0:       return 16'h0001;
                    1:       return 16'h0041;
                    2:       return 16'h006F;
                    default: return 16'h002B;
                endcase
            end
        endcase
    endfunction

    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(5, 20);
    endfunction

    task automatic send_item(input logic [15:0] sw, input logic [3:0] tgt, input logic rdy,
                             input bit typed, input t_result typed_res,
                             output logic [3:0] hop);
        int      gap;
        t_result r;
        gap = calm ? 0 : idle_length();
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) begin
                i_status_word  = 16'($urandom_range(0, 65535));
                i_target_state = 4'($urandom_range(0, 15));
                i_layer_ready  = 1'($urandom_range(0, 1));
                @(negedge i_clk);
            end
        end
        i_status_word  = sw;
        i_target_state = tgt;
        i_layer_ready  = rdy;
        i_valid        = 1'b1;
        do @(posedge i_clk); while (o_stall);
        r   = drive_response(sw, tgt, rdy);
        hop = r.hop_state;
        pending_responses.push_back(typed ? typed_res : r);
    endtask

    task automatic wait_for_results();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending_responses.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic compare_field(input string field, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_valid === 1'b1 && !i_stall) begin
            if (pending_responses.size() == 0) begin
                $display("%0t: unexpected transfer, expected none actual state %0h",
                         $time, o_drive_state);
                mismatches++;
            end else begin
                want = pending_responses.pop_front();
                compare_field("drive_state", 16'(want.drive_state), 16'(o_drive_state));
                compare_field("state_changed", 16'(want.state_changed),
                              16'(o_state_changed));
                compare_field("hop_state", 16'(want.hop_state), 16'(o_hop_state));
                compare_field("control_word", want.control_word, o_control_word);
                compare_field("transition_ok", 16'(want.transition_ok),
                              16'(o_transition_ok));
                compare_field("at_target", 16'(want.at_target), 16'(o_at_target));
                compare_field("limit_status", 16'(want.limit_status), 16'(o_limit_status));
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        i_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (stall_left == 0)
                stall_left = calm ? 0 : idle_length();
            if (stall_left > 0) begin
                i_stall = 1'b1;
                stall_left--;
            end else begin
                i_stall = 1'b0;
            end
        end
    end

    initial begin
        t_row        script[$];
        logic [15:0] sw;
        logic [3:0]  tgt;
        logic [3:0]  hop;
        logic [3:0]  follow;
        logic [3:0]  st;
        int          r;
        script = '{
            '{16'h0000, ST_NOT_READY, 1'b1, 1'b1,
              '{ST_NOT_READY, 1'b1, ST_NOT_READY, 16'h0000, 1'b1, 1'b1, LIM_NONE}},
            '{16'hFFFF, 4'd15, 1'b0, 1'b1,
              '{ST_UNKNOWN, 1'b1, 4'd15, 16'h0000, 1'b0, 1'b0, LIM_WARN}},
            '{16'h0040, ST_DISABLED, 1'b1, 1'b1,
              '{ST_DISABLED, 1'b1, ST_DISABLED, 16'h0000, 1'b1, 1'b1, LIM_NONE}},
            '{16'h0840, ST_DISABLED, 1'b1, 1'b1,
              '{ST_DISABLED, 1'b0, ST_DISABLED, 16'h0000, 1'b1, 1'b1, LIM_ERROR}},
            '{16'h0840, ST_DISABLED, 1'b1, 1'b1,
              '{ST_DISABLED, 1'b0, ST_DISABLED, 16'h0000, 1'b1, 1'b1, LIM_WARN}},
            '{16'h0040, ST_ENABLED,    1'b1, 1'b0, '0},
            '{16'h0021, ST_ENABLED,    1'b1, 1'b0, '0},
            '{16'h0023, ST_ENABLED,    1'b1, 1'b0, '0},
            '{16'h0027, ST_ENABLED,    1'b1, 1'b0, '0},
            '{16'h0007, ST_ENABLED,    1'b0, 1'b0, '0},
            '{16'h0007, ST_DISABLED,   1'b1, 1'b0, '0},
            '{16'h002F, ST_FAULT,      1'b1, 1'b0, '0},
            '{16'h0008, ST_DISABLED,   1'b1, 1'b0, '0},
            '{16'h0028, ST_ENABLED,    1'b1, 1'b0, '0},
            '{16'h0020, ST_ENABLED,    1'b1, 1'b0, '0},
            '{16'h0001, ST_ENABLED,    1'b1, 1'b0, '0},
            '{16'h0027, ST_SWITCHED,   1'b1, 1'b0, '0},
            '{16'h0027, ST_READY,      1'b1, 1'b0, '0},
            '{16'h0027, ST_QUICK_STOP, 1'b1, 1'b0, '0},
            '{16'h0021, ST_QUICK_STOP, 1'b1, 1'b0, '0},
            '{16'h0060, ST_FAULT_RXN,  1'b1, 1'b0, '0},
            '{16'h0021, ST_UNKNOWN,    1'b1, 1'b0, '0},
            '{16'hF7B0, ST_ENABLED,    1'b1, 1'b0, '0},
            '{16'h0823, ST_DISABLED,   1'b0, 1'b0, '0}
        };
        seen_state     = ST_UNKNOWN;
        control_kept   = '0;
        limit_seen     = 1'b0;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_status_word  = '0;
        i_target_state = '0;
        i_layer_ready  = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (script[k])
            send_item(script[k].sw, script[k].tgt, script[k].rdy, script[k].typed,
                      script[k].res, hop);

        wait_for_results();

        follow = ST_UNKNOWN;
        for (int k = 0; k < N_RANDOM; k++) begin
            calm = (k >= 150 && k < 200);
            if ($urandom_range(0, 99) < 15) begin
                sw = 16'($urandom_range(0, 65535));
            end else begin
                st = ($urandom_range(0, 99) < 65) ? follow : 4'($urandom_range(0, 8));
                sw = (16'($urandom_range(0, 65535)) & ~STATE_BITS) | status_bits_for(st);
                sw[SW_LIMIT_BIT] = $urandom_range(0, 99) < 30;
            end
            r = $urandom_range(0, 99);
            if (r < 40)
                tgt = ST_ENABLED;
            else if (r < 88)
                tgt = 4'($urandom_range(0, 8));
            else
                tgt = 4'($urandom_range(9, 15));
            send_item(sw, tgt, $urandom_range(0, 99) < 80, 1'b0, '0, hop);
            follow = (hop > ST_FAULT) ? 4'($urandom_range(0, 8)) : hop;
            if (k == 300)
                wait_for_results();
        end
        calm = 1'b0;

        wait_for_results();
        repeat (8) @(negedge i_clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/dsc_pkg.sv
hw/rtl/dsc_xlate.sv
hw/rtl/drive_state_controller_unit.sv
tb/sv/tb_top.sv
